// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the marquee RTL.
// Included by any module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/stm_pkg.sv =====
// Shared types, constants and helper functions for the scrolling text marquee.
// No dependencies; imported by the marquee core.
package stm_pkg;

   // Field widths fixed by the interface.
   localparam int FUNC_W      = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // Default depth of the text store.
   localparam int TEXT_DEPTH_DEFAULT = 256;

   // Widest row that is ever drawn.
   localparam logic [6:0] MAX_COLUMNS = 7'd64;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_TICKS    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VISIBLE_WIDTH = 8'd1;

   // Register reset values.
   localparam logic [15:0] STEP_RESET  = 16'd155;
   localparam logic [6:0]  WIDTH_RESET = 7'd64;

   // Drawing constants.
   localparam logic [8:0] GAP_BLANKS  = 9'd3;
   localparam logic [7:0] CHAR_BLANK  = 8'h20;
   localparam logic [7:0] COLOR_BLANK = 8'h0A;
   localparam logic [2:0] PALETTE_LAST = 3'd6;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_TICK_CHECK,
      ST_TICK_STEP,
      ST_DRAW_INIT,
      ST_DRAW
   } state_type;

   // Rotating palette, one entry per position modulo seven.
   function automatic logic [7:0] palette_color(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h0C;
         3'd1:    c = 8'h0E;
         3'd2:    c = 8'h0A;
         3'd3:    c = 8'h0B;
         3'd4:    c = 8'h09;
         3'd5:    c = 8'h0D;
         3'd6:    c = 8'h0F;
         default: c = 8'h0C;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/stm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the marquee text store.
module stm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/scrolling_text_marquee_core.sv =====
// Scrolling text marquee core: one request at a time under a small sequencer.
// Load reduces the store index modulo the depth when the store is under 256 deep, then writes.
// Start or stop redraws the row; a due tick steps the scroll and redraws; an idle tick draws nothing.
// Cells leave at one per cycle through one output register; a stalled output holds the row.
// Synchronous active-high reset turns the marquee off and restores the register defaults.
// Depends on stm_pkg, stm_ram and assert_macros.svh.
`include "assert_macros.svh"

module scrolling_text_marquee_core #(
   parameter int TEXT_DEPTH = stm_pkg::TEXT_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [stm_pkg::FUNC_W-1:0]      req_func,
   input  logic [7:0]                      req_text_index,
   input  logic [7:0]                      req_text_char,
   input  logic [7:0]                      req_text_length,
   input  logic [31:0]                     req_tick_now,
   // Result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [5:0]                      rsp_column,
   output logic [7:0]                      rsp_cell_char,
   output logic [7:0]                      rsp_cell_color,
   output logic                            rsp_default_color,
   output logic                            rsp_last_cell,
   // Configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [stm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import stm_pkg::*;

   localparam int AW = $clog2(TEXT_DEPTH);
   // Longest text that fits the store, as an 8-bit length.
   localparam logic [7:0] LEN_LIMIT = (TEXT_DEPTH - 1 > 255) ? 8'd255 : 8'(TEXT_DEPTH - 1);
   // Store index wraps at the depth; indexes never reach 256.
   localparam logic [8:0] IDX_WRAP = (TEXT_DEPTH > 256) ? 9'd256 : 9'(TEXT_DEPTH);

   // Control state
   state_type   state_ff, state_in;
   logic [15:0] step_ticks_ff, step_ticks_in;
   logic [6:0]  vis_width_ff, vis_width_in;
   logic [7:0]  shown_len_ff, shown_len_in;
   logic [8:0]  scroll_ff, scroll_in;
   logic [2:0]  scroll_mod7_ff, scroll_mod7_in;
   logic [31:0] due_ff, due_in;
   logic        running_ff, running_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Payload and draw counters
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  char_ff, char_in;
   logic [31:0] now_ff, now_in;
   logic [5:0]  x_ff, x_in;
   logic [8:0]  p_ff, p_in;
   logic [2:0]  c7_ff, c7_in;
   logic [5:0]  rsp_column_ff, rsp_column_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic [7:0]  rsp_color_ff, rsp_color_in;
   logic        rsp_dflt_ff, rsp_dflt_in;
   logic        rsp_last_ff, rsp_last_in;

   // Combinational control
   logic        req_accept;
   logic        idx_wrap;
   logic        tick_go;
   logic        emit;
   logic        cell_last;
   logic        blank_row;
   logic        ram_we;
   logic [7:0]  ram_rd_data;
   logic [31:0] add_b;
   logic [31:0] add_sum;
   logic        add_cin;
   logic [6:0]  draw_width;
   logic [8:0]  cycle_len;
   logic [7:0]  cell_char;

   // Text store.
   stm_ram #(
      .WIDTH (8),
      .DEPTH (TEXT_DEPTH)
   ) u_text_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(idx_ff)),
      .wr_data (char_ff),
      .rd_addr (AW'(p_in)),
      .rd_data (ram_rd_data)
   );

   // Shared 32-bit adder: due check subtracts, step scheduling adds.
   always_comb begin
      add_cin = (state_ff == ST_TICK_CHECK);
      add_b   = add_cin ? ~due_ff : {16'b0, step_ticks_ff};
      add_sum = now_ff + add_b + {31'b0, add_cin};
   end

   // Derived values used by several branches.
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      req_accept = req_valid && !req_stall;
      idx_wrap   = ({1'b0, idx_ff} >= IDX_WRAP);
      blank_row  = !running_ff || (shown_len_ff == 8'd0);
      tick_go    = !blank_row && !add_sum[31];
      cycle_len  = {1'b0, shown_len_ff} + GAP_BLANKS;
      if (vis_width_ff == 7'd0) begin
         draw_width = 7'd1;
      end else if (vis_width_ff > MAX_COLUMNS) begin
         draw_width = MAX_COLUMNS;
      end else begin
         draw_width = vis_width_ff;
      end
      cell_last = (({1'b0, x_ff} + 7'd1) == draw_width);
      emit      = (state_ff == ST_DRAW) && (!rsp_valid_ff || !rsp_stall);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_LOAD:  state_in = ST_LOAD;
                  FUNC_START: state_in = ST_DRAW_INIT;
                  FUNC_STOP:  state_in = ST_DRAW_INIT;
                  FUNC_TICK:  state_in = ST_TICK_CHECK;
               endcase
            end
         end
         ST_LOAD: begin
            if (!idx_wrap) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_CHECK: state_in = tick_go ? ST_TICK_STEP : ST_IDLE;
         ST_TICK_STEP:  state_in = ST_DRAW_INIT;
         ST_DRAW_INIT:  state_in = ST_DRAW;
         ST_DRAW: begin
            if (emit && cell_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs per state.
   always_comb begin
      step_ticks_in  = step_ticks_ff;
      vis_width_in   = vis_width_ff;
      shown_len_in   = shown_len_ff;
      scroll_in      = scroll_ff;
      scroll_mod7_in = scroll_mod7_ff;
      due_in         = due_ff;
      running_in     = running_ff;
      idx_in         = idx_ff;
      char_in        = char_ff;
      now_in         = now_ff;
      x_in           = x_ff;
      p_in           = p_ff;
      c7_in          = c7_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_column_in  = rsp_column_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_dflt_in    = rsp_dflt_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      cell_char      = CHAR_BLANK;

      // Configuration writes; unknown indexes are dropped.
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_STEP_TICKS) begin
            step_ticks_in = csr_data[15:0];
         end else if (csr_index == CSR_VISIBLE_WIDTH) begin
            vis_width_in = csr_data[6:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               idx_in  = req_text_index;
               char_in = req_text_char;
               now_in  = req_tick_now;
               if (req_func == FUNC_START) begin
                  shown_len_in   = (req_text_length > LEN_LIMIT) ? LEN_LIMIT : req_text_length;
                  scroll_in      = 9'd0;
                  scroll_mod7_in = 3'd0;
                  due_in         = 32'd0;
                  running_in     = 1'b1;
               end else if (req_func == FUNC_STOP) begin
                  running_in = 1'b0;
               end
            end
         end
         ST_LOAD: begin
            // Reduce the index modulo the store depth, then write.
            if (idx_wrap) begin
               idx_in = idx_ff - IDX_WRAP[7:0];
            end else begin
               ram_we = 1'b1;
            end
         end
         ST_TICK_CHECK: begin
         end
         ST_TICK_STEP: begin
            // Advance the offset around text plus gap, and the palette phase with it.
            if ((scroll_ff + 9'd1) == cycle_len) begin
               scroll_in      = 9'd0;
               scroll_mod7_in = 3'd0;
            end else begin
               scroll_in      = scroll_ff + 9'd1;
               scroll_mod7_in = (scroll_mod7_ff == PALETTE_LAST) ? 3'd0 : scroll_mod7_ff + 3'd1;
            end
            due_in = add_sum;
         end
         ST_DRAW_INIT: begin
            // The first position is the offset itself, already below the cycle length.
            x_in  = 6'd0;
            p_in  = scroll_ff;
            c7_in = scroll_mod7_ff;
         end
         ST_DRAW: begin
            if (!blank_row && (p_ff < {1'b0, shown_len_ff})) begin
               cell_char = ram_rd_data;
            end
            if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_column_in = x_ff;
               rsp_char_in   = cell_char;
               rsp_dflt_in   = blank_row;
               rsp_last_in   = cell_last;
               if (blank_row) begin
                  rsp_color_in = 8'h00;
               end else if (cell_char == CHAR_BLANK) begin
                  rsp_color_in = COLOR_BLANK;
               end else begin
                  rsp_color_in = palette_color(c7_ff);
               end
               x_in  = x_ff + 6'd1;
               p_in  = ((p_ff + 9'd1) == cycle_len) ? 9'd0 : p_ff + 9'd1;
               c7_in = (c7_ff == PALETTE_LAST) ? 3'd0 : c7_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ticks_ff  <= STEP_RESET;
         vis_width_ff   <= WIDTH_RESET;
         shown_len_ff   <= 8'd0;
         scroll_ff      <= 9'd0;
         scroll_mod7_ff <= 3'd0;
         due_ff         <= 32'd0;
         running_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ticks_ff  <= step_ticks_in;
         vis_width_ff   <= vis_width_in;
         shown_len_ff   <= shown_len_in;
         scroll_ff      <= scroll_in;
         scroll_mod7_ff <= scroll_mod7_in;
         due_ff         <= due_in;
         running_ff     <= running_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      char_ff       <= char_in;
      now_ff        <= now_in;
      x_ff          <= x_in;
      p_ff          <= p_in;
      c7_ff         <= c7_in;
      rsp_column_ff <= rsp_column_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_dflt_ff   <= rsp_dflt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column        = rsp_column_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_color    = rsp_color_ff;
   assign rsp_default_color = rsp_dflt_ff;
   assign rsp_last_cell     = rsp_last_ff;

   // Checks on the sequencer and the scroll state.
   `ASSERT_CLK(a_cell_from_draw, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAW), "result appeared outside a draw")
   `ASSERT_CLK(a_last_cell_ends, clock, reset, (emit && cell_last) |=> (state_ff == ST_IDLE), "draw did not end after the last cell")
   `ASSERT_CLK(a_scroll_in_range, clock, reset, (running_ff && (shown_len_ff != 8'd0)) |-> (scroll_ff < cycle_len), "scroll offset beyond text plus gap")
   `ASSERT_ALWAYS(a_phase_in_range, clock, (scroll_mod7_ff <= PALETTE_LAST) || reset || $past(reset), "palette phase out of range")

endmodule

// ===== test/scrolling_text_marquee_core_tb.sv =====
// Self-checking testbench for scrolling_text_marquee_core: directed table, then random traffic.
// Predicts drawn cells from its own copy of the marquee state; depends on stm_pkg and the RTL.
module scrolling_text_marquee_core_tb;
   import stm_pkg::*;

   // Expected cell as it leaves the result channel.
   typedef struct packed {
      logic [5:0] column;
      logic [7:0] cell_char;
      logic [7:0] cell_color;
      logic       default_color;
      logic       last_cell;
   } cell_t;

   // How a directed row is checked.
   localparam logic [1:0] ROW_PREDICT = 2'd0;
   localparam logic [1:0] ROW_BLANK   = 2'd1;
   localparam logic [1:0] ROW_QUIET   = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  text_index;
      logic [7:0]  text_char;
      logic [7:0]  text_length;
      logic [31:0] tick_now;
      logic [1:0]  check;
   } stim_row_t;

   localparam int NUM_DIRECTED = 24;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 37;
   // Store entries written before the random phases; random lengths stay within them.
   localparam int FILL_COUNT   = 64;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [7:0]  req_text_index;
   logic [7:0]  req_text_char;
   logic [7:0]  req_text_length;
   logic [31:0] req_tick_now;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_column;
   logic [7:0]  rsp_cell_char;
   logic [7:0]  rsp_cell_color;
   logic        rsp_default_color;
   logic        rsp_last_cell;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   scrolling_text_marquee_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_text_index    (req_text_index),
      .req_text_char     (req_text_char),
      .req_text_length   (req_text_length),
      .req_tick_now      (req_tick_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_column        (rsp_column),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_color    (rsp_cell_color),
      .rsp_default_color (rsp_default_color),
      .rsp_last_cell     (rsp_last_cell),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Marquee state as the testbench tracks it.
   logic [7:0]  text_copy [0:255];
   logic [15:0] step_setting;
   logic [6:0]  width_setting;
   logic [7:0]  shown_len;
   logic [8:0]  scroll_pos;
   logic [31:0] due_at;
   logic        marquee_on;

   logic [7:0] color_wheel [0:6] = '{8'h0C, 8'h0E, 8'h0A, 8'h0B, 8'h09, 8'h0D, 8'h0F};

   cell_t row_cells[$];
   cell_t expected_cells[$];
   int    mismatch_count = 0;
   int    burst_left = 0;
   bit    gaps_on = 1'b1;

   // Directed requests. Blank rows and idle ticks are typed in; the rest is predicted.
   stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
      '{FUNC_STOP,  8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_BLANK},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_QUIET},
      '{FUNC_START, 8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_BLANK},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_QUIET},
      '{FUNC_LOAD,  8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_QUIET},
      '{FUNC_LOAD,  8'h01, 8'hFF, 8'h00, 32'h0000_0000, ROW_QUIET},
      '{FUNC_LOAD,  8'h02, 8'h20, 8'h00, 32'h0000_0000, ROW_QUIET},
      '{FUNC_LOAD,  8'h03, 8'h41, 8'h00, 32'h0000_0000, ROW_QUIET},
      '{FUNC_LOAD,  8'h04, 8'h7E, 8'h00, 32'h0000_0000, ROW_QUIET},
      '{FUNC_START, 8'h00, 8'h00, 8'h05, 32'h0000_0000, ROW_PREDICT},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_PREDICT},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_0064, ROW_QUIET},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_009B, ROW_PREDICT},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, ROW_QUIET},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h8000_0135, ROW_PREDICT},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h8000_0135, ROW_QUIET},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h8000_01D0, ROW_PREDICT},
      '{FUNC_STOP,  8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_BLANK},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, ROW_QUIET},
      '{FUNC_START, 8'h00, 8'h00, 8'h01, 32'h0000_0000, ROW_PREDICT},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_0000, ROW_PREDICT},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h0000_009B, ROW_PREDICT},
      '{FUNC_START, 8'h00, 8'h00, 8'h05, 32'h0000_0000, ROW_PREDICT},
      '{FUNC_TICK,  8'h00, 8'h00, 8'h00, 32'h7FFF_FFFF, ROW_PREDICT}
   };

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #20_000_000;
      $display("scrolling_text_marquee_core_tb: FAIL");
      $finish;
   end

   // Number of columns a redraw emits under the current width setting.
   function automatic int drawn_width();
      if (width_setting == 7'd0)
         return 1;
      if (width_setting > MAX_COLUMNS)
         return 64;
      return int'(width_setting);
   endfunction

   // Build one row of cells from the tracked state.
   task automatic draw_marquee_row();
      int    w;
      int    posv;
      int    p;
      cell_t c;
      w = drawn_width();
      for (int x = 0; x < w; x++) begin
         c.column        = x[5:0];
         c.cell_char     = CHAR_BLANK;
         c.cell_color    = 8'h00;
         c.default_color = 1'b1;
         c.last_cell     = (x + 1 == w);
         if (marquee_on && shown_len != 8'd0) begin
            posv = int'(scroll_pos) + x;
            p    = posv % (int'(shown_len) + 3);
            if (p < int'(shown_len))
               c.cell_char = text_copy[p];
            c.cell_color = (c.cell_char == CHAR_BLANK) ? COLOR_BLANK : color_wheel[posv % 7];
            c.default_color = 1'b0;
         end
         row_cells.push_back(c);
      end
   endtask

   // Apply one accepted request to the tracked state; the cells it draws land in row_cells.
   task automatic predict_request(input logic [1:0] f, input logic [7:0] idx,
                                  input logic [7:0] chr, input logic [7:0] len,
                                  input logic [31:0] now);
      logic [31:0] lag;
      lag = now - due_at;
      row_cells.delete();
      case (f)
         FUNC_LOAD: begin
            text_copy[idx] = chr;
         end
         FUNC_START: begin
            shown_len  = len;
            scroll_pos = 9'd0;
            due_at     = 32'd0;
            marquee_on = 1'b1;
            draw_marquee_row();
         end
         FUNC_STOP: begin
            marquee_on = 1'b0;
            draw_marquee_row();
         end
         default: begin
            // A tick steps only when running, with text, and once the due tick is reached.
            if (marquee_on && shown_len != 8'd0 && !lag[31]) begin
               scroll_pos = 9'((int'(scroll_pos) + 1) % (int'(shown_len) + 3));
               due_at     = now + {16'd0, step_setting};
               draw_marquee_row();
            end
         end
      endcase
   endtask

   // Present one request, wait for it to be taken, then queue what it should draw.
   task automatic send_request(input logic [1:0] f, input logic [7:0] idx, input logic [7:0] chr,
                               input logic [7:0] len, input logic [31:0] now,
                               input logic [1:0] check);
      cell_t c;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_func        <= f;
      req_text_index  <= idx;
      req_text_char   <= chr;
      req_text_length <= len;
      req_tick_now    <= now;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_request(f, idx, chr, len, now);
      if (check == ROW_PREDICT) begin
         foreach (row_cells[i])
            expected_cells.push_back(row_cells[i]);
      end else if (check == ROW_BLANK) begin
         for (int x = 0; x < drawn_width(); x++) begin
            c = '{x[5:0], 8'h20, 8'h00, 1'b1, (x + 1 == drawn_width())};
            expected_cells.push_back(c);
         end
      end
   endtask

   // Drop the request valid for a number of cycles.
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1)
         @(negedge clock);
   endtask

   // Burst pacing of the sender between requests.
   task automatic pace_sender();
      if (burst_left == 0) begin
         if (gaps_on)
            idle_sender($urandom_range(1, 8));
         burst_left = $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   // Hold off until every expected cell has come and the block has settled.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cells.size() != 0)
         @(posedge clock);
      repeat (8)
         @(posedge clock);
   endtask

   // One register write on the configuration channel.
   task automatic write_csr(input logic [7:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == CSR_STEP_TICKS)
         step_setting = data;
      else if (idx == CSR_VISIBLE_WIDTH)
         width_setting = data[6:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver stall pattern: modes of random length, from none to heavy.
   int stall_mode  = 0;
   int stall_timer = 0;
   int stall_phase = 0;
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_timer = $urandom_range(40, 300);
      end else begin
         stall_timer--;
      end
      stall_phase = (stall_phase + 1) % 5;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= (stall_phase < 2);
      endcase
   end

   // Compare each accepted cell with the oldest expectation.
   always @(posedge clock) begin
      cell_t want;
      cell_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_column, rsp_cell_char, rsp_cell_color, rsp_default_color, rsp_last_cell};
         if (expected_cells.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected cell: col %0d char %h color %h dflt %b last %b",
                     $time, got.column, got.cell_char, got.cell_color, got.default_color,
                     got.last_cell);
         end else begin
            want = expected_cells.pop_front();
            if (got !== want) begin
               mismatch_count++;
               $display("%0t: cell mismatch: expected col %0d char %h color %h dflt %b last %b",
                        $time, want.column, want.cell_char, want.cell_color,
                        want.default_color, want.last_cell);
               $display("%0t:                actual   col %0d char %h color %h dflt %b last %b",
                        $time, got.column, got.cell_char, got.cell_color, got.default_color,
                        got.last_cell);
            end
         end
      end
   end

   // Main stimulus.
   initial begin
      logic [15:0] phase_step  [0:NUM_PHASES-1];
      logic [15:0] phase_width [0:NUM_PHASES-1];
      int          counted;
      int          pick;
      logic [1:0]  f;
      logic [7:0]  idx;
      logic [7:0]  chr;
      logic [7:0]  len;
      logic [31:0] now;

      phase_step  = '{16'd0, 16'hFFFF, 16'd1, 16'd7, 16'd0, 16'd155};
      phase_width = '{16'd1, 16'd64, 16'd0, 16'd127, 16'd0, 16'hFFC0};
      phase_step[4]  = 16'($urandom_range(2, 400));
      phase_width[4] = 16'($urandom_range(2, 63));

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_LOAD;
      req_text_index  = 8'd0;
      req_text_char   = 8'd0;
      req_text_length = 8'd0;
      req_tick_now    = 32'd0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_STEP_TICKS;
      csr_data        = 16'd0;
      step_setting    = STEP_RESET;
      width_setting   = WIDTH_RESET;
      shown_len       = 8'd0;
      scroll_pos      = 9'd0;
      due_at          = 32'd0;
      marquee_on      = 1'b0;

      repeat (11)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table at the reset settings.
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         send_request(directed_rows[r].func, directed_rows[r].text_index,
                      directed_rows[r].text_char, directed_rows[r].text_length,
                      directed_rows[r].tick_now, directed_rows[r].check);
         pace_sender();
      end

      // Fill the front of the store so that every random length reads written entries.
      for (int i = 0; i < FILL_COUNT; i++) begin
         send_request(FUNC_LOAD, 8'(i), 8'($urandom_range(0, 255)), 8'd0, 32'd0,
                      ROW_PREDICT);
         pace_sender();
      end

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         write_csr(CSR_STEP_TICKS, phase_step[ph]);
         write_csr(CSR_VISIBLE_WIDTH, phase_width[ph]);
         if (ph == 2)
            write_csr(8'hFE, 16'h0001);
         gaps_on = (ph != 3);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            idx  = 8'($urandom_range(0, 255));
            chr  = 8'($urandom_range(0, 255));
            len  = 8'($urandom_range(0, 255));
            now  = $urandom();
            if (pick < 8) begin
               f = FUNC_LOAD;
            end else if (pick < 18) begin
               f = FUNC_START;
               if ($urandom_range(0, 99) < 75)
                  len = 8'($urandom_range(1, 16));
               else
                  len = 8'($urandom_range(0, FILL_COUNT));
            end else if (pick < 23) begin
               f = FUNC_STOP;
            end else begin
               // Mostly ticks on or just after the due tick, some early, some arbitrary.
               f = FUNC_TICK;
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  now = due_at + 32'($urandom_range(0, 3));
               else if (pick < 85)
                  now = due_at - 32'($urandom_range(1, 1000));
            end
            send_request(f, idx, chr, len, now, ROW_PREDICT);
            counted++;
            if (ph == 1 && counted == 25)
               wait_drained();
            else
               pace_sender();
         end
      end

      // Let everything drain, then watch for stray cells.
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cells.size() != 0)
         @(posedge clock);
      repeat (80)
         @(posedge clock);

      if (mismatch_count == 0)
         $display("scrolling_text_marquee_core_tb: PASS");
      else
         $display("scrolling_text_marquee_core_tb: FAIL");
      $finish;
   end

endmodule

// ===== scrolling_text_marquee_core.f =====
+incdir+rtl
rtl/stm_pkg.sv
rtl/stm_ram.sv
rtl/scrolling_text_marquee_core.sv
test/scrolling_text_marquee_core_tb.sv
